// ===== sv/baro_sensor_compensation_unit_defines.svh =====
// Assertion macros used by the pipeline control of the compensation unit RTL.
`ifndef BARO_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`define BARO_SENSOR_COMPENSATION_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Clocked check, disabled while reset is asserted (active-low reset).
`define BSCU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bscu assertion failed");
// Clocked check that also runs during reset.
`define BSCU_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bscu reset assertion failed");
`else
`define BSCU_ASSERT(lbl, clk, rst_n, prop)
`define BSCU_ASSERT_RST(lbl, clk, prop)
`endif
`endif

// ===== sv/bscu_pkg.sv =====
// Types and constants shared by the compensation unit modules.
package bscu_pkg;

    localparam int NumStages = 9;
    localparam int CfgIdxW   = 3;
    localparam int CfgDataW  = 16;

    localparam logic signed [19:0] TempRef  = 20'sd2000;
    localparam logic signed [19:0] TempVlow = -20'sd1500;

    typedef logic [NumStages-1:0] t_stage_en;

    typedef enum logic [CfgIdxW-1:0] {
        CfgC1     = 3'd0,
        CfgC2     = 3'd1,
        CfgC3     = 3'd2,
        CfgC4     = 3'd3,
        CfgC5     = 3'd4,
        CfgC6     = 3'd5,
        CfgTempSo = 3'd6,
        CfgPresSo = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] c1;
        logic [15:0] c2;
        logic [15:0] c3;
        logic [15:0] c4;
        logic [15:0] c5;
        logic [15:0] c6;
        logic        temp_so;
        logic        press_so;
    } t_cfg;

    // Register defaults, in field order c1..c6, temp_so, press_so.
    localparam t_cfg CfgReset = {16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                 16'h0000, 16'h0000, 1'b0, 1'b1};

    // Hand-off from the temperature half to the pressure half.
    typedef struct packed {
        logic [23:0]        d1;
        logic [35:0]        dd;        // (TEMP-2000)^2
        logic [35:0]        ee;        // (TEMP+1500)^2
        logic               lo;        // TEMP < 2000
        logic               vlo;       // TEMP < -1500
        logic [18:0]        temp_out;
        logic signed [39:0] off;
        logic signed [39:0] sens;
    } t_mid;

endpackage

// ===== sv/bscu_pipe_ctrl.sv =====
// Valid/ready control for the compensation pipeline: per-stage valid and load enables.
`include "baro_sensor_compensation_unit_defines.svh"

module bscu_pipe_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_out_ready,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    output bscu_pkg::t_stage_en  o_en
);

    localparam int N = bscu_pkg::NumStages;

    logic [N-1:0] r_v;
    logic [N-1:0] n_v;
    logic [N-1:0] w_rdy;
    logic         w_in_acc;
    logic         w_out_acc;

    // A stage loads when empty or when the stage after it moves.
    always_comb begin
        w_rdy[N-1] = !r_v[N-1] || i_out_ready;
        for (int k = N-2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    always_comb begin
        n_v = r_v;
        if (w_rdy[0]) begin
            n_v[0] = i_in_valid;
        end
        for (int k = 1; k < N; k++) begin
            if (w_rdy[k]) begin
                n_v[k] = r_v[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    assign o_in_ready  = w_rdy[0];
    assign o_out_valid = r_v[N-1];
    assign o_en        = w_rdy;
    assign w_in_acc    = i_in_valid && w_rdy[0];
    assign w_out_acc   = r_v[N-1] && i_out_ready;

    `BSCU_ASSERT_RST(a_reset_clears, i_clk, !i_rst_n |=> (r_v == '0))
    `BSCU_ASSERT(a_full_when_blocked, i_clk, i_rst_n,
        !w_rdy[0] |-> ((&r_v) && !i_out_ready))
    `BSCU_ASSERT(a_occupancy, i_clk, i_rst_n,
        1'b1 |=> ($countones(r_v) == $past($countones(r_v)) + $past(w_in_acc)
                  - $past(w_out_acc)))

endmodule

// ===== sv/bscu_temp_path.sv =====
// Stages 0-3: dT, temperature, first-order OFF/SENS, squares for the band corrections.
module bscu_temp_path (
    input  logic                i_clk,
    input  bscu_pkg::t_stage_en i_en,
    input  bscu_pkg::t_cfg      i_cfg,
    input  logic [23:0]         i_raw_pressure,
    input  logic [23:0]         i_raw_temperature,
    output bscu_pkg::t_mid      o_mid
);

    // stage 0
    logic [23:0]        r_d1_s0;
    logic signed [24:0] r_dt;
    logic signed [24:0] n_dt;

    assign n_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, i_cfg.c5, 8'h00});

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_d1_s0 <= i_raw_pressure;
            r_dt    <= n_dt;
        end
    end

    // stage 1: products of dT
    logic [23:0]        r_d1_s1;
    logic signed [41:0] r_p6, r_p4, r_p3;
    logic [47:0]        r_sq;
    logic signed [41:0] n_p6, n_p4, n_p3;
    logic signed [49:0] n_sq;

    assign n_p6 = r_dt * $signed({1'b0, i_cfg.c6});
    assign n_p4 = r_dt * $signed({1'b0, i_cfg.c4});
    assign n_p3 = r_dt * $signed({1'b0, i_cfg.c3});
    assign n_sq = r_dt * r_dt;

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_d1_s1 <= r_d1_s0;
            r_p6    <= n_p6;
            r_p4    <= n_p4;
            r_p3    <= n_p3;
            r_sq    <= n_sq[47:0];
        end
    end

    // stage 2: truncating shifts, TEMP, OFF, SENS
    logic [23:0]        r_d1_s2;
    logic signed [19:0] r_temp;
    logic signed [39:0] r_off, r_sens;
    logic [16:0]        r_t2;
    logic signed [41:0] n_p6b, n_p4b, n_p3b;
    logic signed [19:0] n_temp;
    logic signed [39:0] n_off, n_sens;

    // bias negatives so the arithmetic shift rounds toward zero
    assign n_p6b = r_p6 + (r_p6[41] ? 42'sd8388607 : 42'sd0);
    assign n_p4b = r_p4 + (r_p4[41] ? 42'sd127 : 42'sd0);
    assign n_p3b = r_p3 + (r_p3[41] ? 42'sd255 : 42'sd0);

    assign n_temp = $signed({n_p6b[41], n_p6b[41:23]}) + bscu_pkg::TempRef;
    assign n_off  = $signed({8'h00, i_cfg.c2, 16'h0000})
                  + $signed({{5{n_p4b[41]}}, n_p4b[41:7]});
    assign n_sens = $signed({9'h000, i_cfg.c1, 15'h0000})
                  + $signed({{6{n_p3b[41]}}, n_p3b[41:8]});

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_d1_s2 <= r_d1_s1;
            r_temp  <= n_temp;
            r_off   <= n_off;
            r_sens  <= n_sens;
            r_t2    <= r_sq[47:31];
        end
    end

    // stage 3: band squares, band flags, corrected temperature
    bscu_pkg::t_mid     r_mid;
    logic signed [19:0] n_d, n_e, n_t_corr, n_temp_out;
    logic signed [39:0] n_dd, n_ee;
    logic               n_lo, n_vlo;

    assign n_d        = r_temp - bscu_pkg::TempRef;
    assign n_e        = r_temp - bscu_pkg::TempVlow;
    assign n_dd       = n_d * n_d;
    assign n_ee       = n_e * n_e;
    assign n_lo       = r_temp < bscu_pkg::TempRef;
    assign n_vlo      = r_temp < bscu_pkg::TempVlow;
    assign n_t_corr   = r_temp - $signed({3'b000, r_t2});
    assign n_temp_out = (i_cfg.temp_so && n_lo) ? n_t_corr : r_temp;

    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            r_mid.d1       <= r_d1_s2;
            r_mid.dd       <= n_dd[35:0];
            r_mid.ee       <= n_ee[35:0];
            r_mid.lo       <= n_lo;
            r_mid.vlo      <= n_vlo;
            r_mid.temp_out <= n_temp_out[18:0];
            r_mid.off      <= r_off;
            r_mid.sens     <= r_sens;
        end
    end

    assign o_mid = r_mid;

endmodule

// ===== sv/bscu_press_path.sv =====
// Stages 4-8: second-order OFF/SENS, split D1*SENS product, pressure divides, output regs.
module bscu_press_path (
    input  logic                i_clk,
    input  bscu_pkg::t_stage_en i_en,
    input  logic                i_press_so,
    input  bscu_pkg::t_mid      i_mid,
    output logic signed [18:0]  o_temperature_centi,
    output logic signed [31:0]  o_pressure_centi_mbar
);

    // stage 4: OFF2 / SENS2 by shift-add
    logic [23:0]        r_d1_s4;
    logic [18:0]        r_to_s4;
    logic signed [39:0] r_off_s4, r_sens_s4;
    logic [39:0]        n_dd40, n_ee40, n_m5, n_m7, n_m11, n_off2, n_sens2;
    logic signed [39:0] n_off_c, n_sens_c;

    assign n_dd40  = {4'h0, i_mid.dd};
    assign n_ee40  = {4'h0, i_mid.ee};
    assign n_m5    = (n_dd40 << 2) + n_dd40;
    assign n_m7    = (n_ee40 << 3) - n_ee40;
    assign n_m11   = (n_ee40 << 3) + (n_ee40 << 1) + n_ee40;
    assign n_off2  = (i_mid.lo ? (n_m5 >> 1) : 40'd0) + (i_mid.vlo ? n_m7 : 40'd0);
    assign n_sens2 = (i_mid.lo ? (n_m5 >> 2) : 40'd0) + (i_mid.vlo ? (n_m11 >> 1) : 40'd0);
    assign n_off_c  = i_press_so ? (i_mid.off - $signed(n_off2)) : i_mid.off;
    assign n_sens_c = i_press_so ? (i_mid.sens - $signed(n_sens2)) : i_mid.sens;

    always_ff @(posedge i_clk) begin
        if (i_en[4]) begin
            r_d1_s4   <= i_mid.d1;
            r_to_s4   <= i_mid.temp_out;
            r_off_s4  <= n_off_c;
            r_sens_s4 <= n_sens_c;
        end
    end

    // stage 5: D1 times low and high halves of SENS
    logic [18:0]        r_to_s5;
    logic signed [39:0] r_off_s5;
    logic [43:0]        r_pl;
    logic signed [43:0] r_ph;
    logic [43:0]        n_pl;
    logic signed [44:0] n_ph;

    assign n_pl = r_d1_s4 * r_sens_s4[19:0];
    assign n_ph = $signed({1'b0, r_d1_s4}) * $signed(r_sens_s4[39:20]);

    always_ff @(posedge i_clk) begin
        if (i_en[5]) begin
            r_to_s5  <= r_to_s4;
            r_off_s5 <= r_off_s4;
            r_pl     <= n_pl;
            r_ph     <= n_ph[43:0];
        end
    end

    // stage 6: recombine the 64-bit product
    logic [18:0]        r_to_s6;
    logic signed [39:0] r_off_s6;
    logic signed [63:0] r_prod;
    logic signed [63:0] n_prod;

    assign n_prod = $signed({r_ph, 20'h00000}) + $signed({20'h00000, r_pl});

    always_ff @(posedge i_clk) begin
        if (i_en[6]) begin
            r_to_s6  <= r_to_s5;
            r_off_s6 <= r_off_s5;
            r_prod   <= n_prod;
        end
    end

    // stage 7: /2^21 toward zero, minus OFF
    logic [18:0]        r_to_s7;
    logic signed [43:0] r_x;
    logic signed [63:0] n_prodb;
    logic signed [43:0] n_x;

    assign n_prodb = r_prod + (r_prod[63] ? 64'sd2097151 : 64'sd0);
    assign n_x     = $signed({n_prodb[63], n_prodb[63:21]})
                   - $signed({{4{r_off_s6[39]}}, r_off_s6});

    always_ff @(posedge i_clk) begin
        if (i_en[7]) begin
            r_to_s7 <= r_to_s6;
            r_x     <= n_x;
        end
    end

    // stage 8: /2^15 toward zero, output registers
    logic [18:0]        r_to_s8;
    logic [31:0]        r_p;
    logic signed [43:0] n_xb;
    logic [31:0]        n_p;

    assign n_xb = r_x + (r_x[43] ? 44'sd32767 : 44'sd0);
    assign n_p  = {{3{n_xb[43]}}, n_xb[43:15]};

    always_ff @(posedge i_clk) begin
        if (i_en[8]) begin
            r_to_s8 <= r_to_s7;
            r_p     <= n_p;
        end
    end

    assign o_temperature_centi   = $signed(r_to_s8);
    assign o_pressure_centi_mbar = $signed(r_p);

endmodule

// ===== sv/baro_sensor_compensation_unit.sv =====
// Top level of the barometric sensor compensation unit: config registers and pipeline.
//
//  channel  | direction | handshake                  | payload
//  ---------+-----------+----------------------------+------------------------------------
//  input    | in        | i_in_valid / o_in_ready    | i_raw_pressure, i_raw_temperature
//  result   | out       | o_out_valid / i_out_ready  | o_temperature_centi,
//           |           |                            | o_pressure_centi_mbar
//  config   | in        | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while i_out_ready is high; an accepted item passes through
// the nine register stages of the pipeline, the first of which loads at the accepting edge,
// before o_out_valid rises (multiplier stages and the split 24x40 pressure product).
// Synchronous active-low reset clears the stage valid bits and loads the register
// defaults (coefficients 0, temperature correction off, pressure correction on).
// A stall on the result side holds the final stage; earlier stages keep moving into
// empty slots, so the input keeps accepting until every stage holds an item.
module baro_sensor_compensation_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [23:0]                   i_raw_pressure,
    input  logic [23:0]                   i_raw_temperature,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [18:0]            o_temperature_centi,
    output logic signed [31:0]            o_pressure_centi_mbar,
    input  logic                          i_cfg_we,
    input  logic [bscu_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [bscu_pkg::CfgDataW-1:0] i_cfg_data
);

    bscu_pkg::t_cfg      r_cfg;
    bscu_pkg::t_cfg      n_cfg;
    bscu_pkg::t_stage_en w_en;
    bscu_pkg::t_mid      w_mid;

    // Register file: wide values keep their low bits.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (bscu_pkg::t_cfg_idx'(i_cfg_index))
                bscu_pkg::CfgC1:     n_cfg.c1       = i_cfg_data;
                bscu_pkg::CfgC2:     n_cfg.c2       = i_cfg_data;
                bscu_pkg::CfgC3:     n_cfg.c3       = i_cfg_data;
                bscu_pkg::CfgC4:     n_cfg.c4       = i_cfg_data;
                bscu_pkg::CfgC5:     n_cfg.c5       = i_cfg_data;
                bscu_pkg::CfgC6:     n_cfg.c6       = i_cfg_data;
                bscu_pkg::CfgTempSo: n_cfg.temp_so  = i_cfg_data[0];
                bscu_pkg::CfgPresSo: n_cfg.press_so = i_cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= bscu_pkg::CfgReset;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Stage valids and load enables.
    bscu_pipe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_en        (w_en)
    );

    // dT, TEMP, first-order OFF/SENS, band squares.
    bscu_temp_path u_temp (
        .i_clk             (i_clk),
        .i_en              (w_en),
        .i_cfg             (r_cfg),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .o_mid             (w_mid)
    );

    // Second-order correction and pressure.
    bscu_press_path u_press (
        .i_clk                 (i_clk),
        .i_en                  (w_en),
        .i_press_so            (r_cfg.press_so),
        .i_mid                 (w_mid),
        .o_temperature_centi   (o_temperature_centi),
        .o_pressure_centi_mbar (o_pressure_centi_mbar)
    );

endmodule

// ===== test/tb_baro_sensor_compensation_unit.sv =====
// Self-checking testbench for the barometric sensor compensation unit.
module tb_baro_sensor_compensation_unit;

    // Compensation constants, all kept in 64-bit signed math.
    localparam longint TempRefC     = 2000;
    localparam longint TempVlowC    = -1500;
    localparam longint OffScale     = 65536;
    localparam longint OffTcDiv     = 128;
    localparam longint SensScale    = 32768;
    localparam longint SensTcDiv    = 256;
    localparam longint TempDiv      = 8388608;
    localparam longint PressDiv1    = 2097152;
    localparam longint PressDiv2    = 32768;
    localparam longint T2Div        = 64'sd2147483648;
    localparam longint Sens2VlowMul = 11;
    localparam longint RawMax       = 16777215;

    localparam int CycleLimit   = 300000;
    localparam int DrainCycles  = 12;
    localparam int PhaseCount   = 12;
    localparam int PhaseItems   = 150;

    typedef struct packed {
        logic signed [18:0] temp_centi;
        logic signed [31:0] press_centi;
    } t_reading_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    logic [23:0]                     i_raw_pressure = '0;
    logic [23:0]                     i_raw_temperature = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic signed [18:0]              o_temperature_centi;
    logic signed [31:0]              o_pressure_centi_mbar;
    logic                            i_cfg_we = 1'b0;
    logic [bscu_pkg::CfgIdxW-1:0]    i_cfg_index = '0;
    logic [bscu_pkg::CfgDataW-1:0]   i_cfg_data = '0;

    // Mirror of the calibration registers
    logic [15:0] cal_c1, cal_c2, cal_c3, cal_c4, cal_c5, cal_c6;
    logic        temp_corr_en;
    logic        press_corr_en;

    t_reading_result pending_results[$];
    int              mismatch_count = 0;
    int              cycle_count = 0;
    int              in_idle_pct = 26;
    int              out_idle_pct = 26;

    baro_sensor_compensation_unit uut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_raw_pressure        (i_raw_pressure),
        .i_raw_temperature     (i_raw_temperature),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_temperature_centi   (o_temperature_centi),
        .o_pressure_centi_mbar (o_pressure_centi_mbar),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Temperature and second-order pressure compensation of one reading pair.
    function automatic t_reading_result compensate_reading(input logic [23:0] raw_p,
                                                           input logic [23:0] raw_t);
        t_reading_result res;
        longint d1, dt, temp, off, sens, off2, sens2, dd, ee, press, temp_fin;
        d1    = longint'(raw_p);
        dt    = longint'(raw_t) - longint'(cal_c5) * 256;
        temp  = TempRefC + (dt * longint'(cal_c6)) / TempDiv;
        off   = longint'(cal_c2) * OffScale + (longint'(cal_c4) * dt) / OffTcDiv;
        sens  = longint'(cal_c1) * SensScale + (longint'(cal_c3) * dt) / SensTcDiv;
        off2  = 0;
        sens2 = 0;
        if (press_corr_en) begin
            if (temp < TempRefC) begin
                dd    = (temp - TempRefC) * (temp - TempRefC);
                off2  = (5 * dd) / 2;
                sens2 = (5 * dd) / 4;
            end
            if (temp < TempVlowC) begin
                ee    = (temp - TempVlowC) * (temp - TempVlowC);
                off2  = off2 + 7 * ee;
                sens2 = sens2 + (Sens2VlowMul * ee) / 2;
            end
            off  = off - off2;
            sens = sens - sens2;
        end
        press = ((d1 * sens) / PressDiv1 - off) / PressDiv2;
        temp_fin = temp;
        // low-temperature correction uses a 64-bit square of dT
        if (temp_corr_en && temp < TempRefC) begin
            temp_fin = temp - (dt * dt) / T2Div;
        end
        res.temp_centi  = temp_fin[18:0];
        res.press_centi = press[31:0];
        return res;
    endfunction

    // Result side: random back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end

    // Result checker: each accepted item against the oldest prediction
    always @(posedge i_clk) begin
        t_reading_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t unexpected item: temperature %0d pressure %0d", $time,
                         o_temperature_centi, o_pressure_centi_mbar);
            end else begin
                want = pending_results.pop_front();
                if (o_temperature_centi !== want.temp_centi) begin
                    mismatch_count++;
                    $display("%0t temperature mismatch: expected %0d actual %0d", $time,
                             want.temp_centi, o_temperature_centi);
                end
                if (o_pressure_centi_mbar !== want.press_centi) begin
                    mismatch_count++;
                    $display("%0t pressure mismatch: expected %0d actual %0d", $time,
                             want.press_centi, o_pressure_centi_mbar);
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("%0t timeout after %0d cycles", $time, cycle_count);
            $display("[baro_sensor_compensation_unit] ERROR");
            $finish;
        end
    end

    task automatic apply_reset();
        cal_c1 = '0;
        cal_c2 = '0;
        cal_c3 = '0;
        cal_c4 = '0;
        cal_c5 = '0;
        cal_c6 = '0;
        temp_corr_en  = 1'b0;
        press_corr_en = 1'b1;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // Present one reading pair and log its prediction once accepted.
    task automatic send_reading(input logic [23:0] raw_p, input logic [23:0] raw_t);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_raw_pressure    <= raw_p;
        i_raw_temperature <= raw_t;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_results.push_back(compensate_reading(raw_p, raw_t));
    endtask

    // Hold the input off until every outstanding item has come back.
    task automatic wait_results_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input bscu_pkg::t_cfg_idx idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            bscu_pkg::CfgC1:     cal_c1 = data;
            bscu_pkg::CfgC2:     cal_c2 = data;
            bscu_pkg::CfgC3:     cal_c3 = data;
            bscu_pkg::CfgC4:     cal_c4 = data;
            bscu_pkg::CfgC5:     cal_c5 = data;
            bscu_pkg::CfgC6:     cal_c6 = data;
            bscu_pkg::CfgTempSo: temp_corr_en = data[0];
            bscu_pkg::CfgPresSo: press_corr_en = data[0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Flag registers take full 16-bit words; only bit 0 counts.
    task automatic load_calibration(input logic [15:0] c1, input logic [15:0] c2,
                                    input logic [15:0] c3, input logic [15:0] c4,
                                    input logic [15:0] c5, input logic [15:0] c6,
                                    input logic [15:0] tso, input logic [15:0] pso);
        wait_results_drained();
        write_reg(bscu_pkg::CfgC1, c1);
        write_reg(bscu_pkg::CfgC2, c2);
        write_reg(bscu_pkg::CfgC3, c3);
        write_reg(bscu_pkg::CfgC4, c4);
        write_reg(bscu_pkg::CfgC5, c5);
        write_reg(bscu_pkg::CfgC6, c6);
        write_reg(bscu_pkg::CfgTempSo, tso);
        write_reg(bscu_pkg::CfgPresSo, pso);
    endtask

    // Reset values: zero coefficients, pressure correction on.
    task automatic test_reset_defaults();
        send_reading(24'd0, 24'd0);
        send_reading(24'hFFFFFF, 24'hFFFFFF);
        send_reading(24'hFFFFFF, 24'd0);
        send_reading(24'd0, 24'hFFFFFF);
    endtask

    // c5 = c6 = 32768 puts the reference at D2 = 8388608 and TEMP = 2000 + dT/256,
    // so band edges and truncation toward zero land on exact raw values.
    task automatic test_temperature_bands();
        load_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282,
                         16'd32768, 16'd32768, 16'h0001, 16'h0001);
        send_reading(24'd9085466, 24'd8388608);   // warm edge, dT = 0
        send_reading(24'd9085466, 24'd8388607);   // dT = -1 truncates to TEMP 2000
        send_reading(24'd9085466, 24'd8388353);   // still 2000
        send_reading(24'd9085466, 24'd8388352);   // 1999: low band
        send_reading(24'd9085466, 24'd7492608);   // -1500: low band only
        send_reading(24'd9085466, 24'd7492352);   // -1501: very low band
        send_reading(24'd0, 24'd0);               // coldest reading
        send_reading(24'hFFFFFF, 24'hFFFFFF);     // hottest reading
    endtask

    // All four correction combinations, flags written with junk upper bits.
    task automatic test_correction_modes();
        logic [15:0] tso, pso;
        for (int mode = 0; mode < 4; mode++) begin
            tso = mode[0] ? 16'h8001 : 16'hFFFE;
            pso = mode[1] ? 16'h7FFF : 16'hAAAA;
            load_calibration(16'd40127, 16'd36924, 16'd23317, 16'd23282,
                             16'd32768, 16'd32768, tso, pso);
            send_reading(24'd9085466, 24'd5000000);
            send_reading(24'd9085466, 24'd9000000);
        end
    endtask

    task automatic test_coefficient_extremes();
        load_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'h0000, 16'hFFFF, 16'h0001, 16'h0001);
        send_reading(24'd0, 24'd0);
        send_reading(24'hFFFFFF, 24'hFFFFFF);
        send_reading(24'hFFFFFF, 24'd0);
        // largest reference: deepest cold, biggest correction terms
        load_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                         16'hFFFF, 16'hFFFF, 16'h0001, 16'h0001);
        send_reading(24'hFFFFFF, 24'd0);
        send_reading(24'd0, 24'd0);
    endtask

    // Phases of random readings, each under a fresh calibration.
    task automatic test_random_traffic();
        logic [23:0] raw_p, raw_t;
        longint      near_t;
        for (int phase = 0; phase < PhaseCount; phase++) begin
            if (phase == 0) begin
                load_calibration(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 16'hFFFF, 16'($urandom), 16'($urandom));
            end else if (phase == 1) begin
                load_calibration(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                 16'h0000, 16'($urandom), 16'($urandom));
            end else begin
                load_calibration(16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom), 16'($urandom),
                                 16'($urandom), 16'($urandom));
            end
            // one phase runs flat out with no bubbles on either side
            in_idle_pct  = (phase == 4) ? 0 : 26;
            out_idle_pct = (phase == 4) ? 0 : 26;
            for (int n = 0; n < PhaseItems; n++) begin
                case ($urandom_range(0, 7))
                    0:       raw_p = 24'd0;
                    1:       raw_p = 24'hFFFFFF;
                    default: raw_p = 24'($urandom);
                endcase
                if ($urandom_range(0, 3) == 0) begin
                    // close to the reference temperature of this calibration
                    near_t = longint'(cal_c5) * 256
                           + longint'($urandom_range(0, 4000000)) - 2000000;
                    if (near_t < 0) near_t = 0;
                    if (near_t > RawMax) near_t = RawMax;
                    raw_t = near_t[23:0];
                end else begin
                    raw_t = 24'($urandom);
                end
                send_reading(raw_p, raw_t);
                if ($urandom_range(0, 99) == 0) wait_results_drained();
            end
        end
        in_idle_pct  = 26;
        out_idle_pct = 26;
    endtask

    task automatic finish_run();
        wait_results_drained();
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[baro_sensor_compensation_unit] OK");
        end else begin
            $display("[baro_sensor_compensation_unit] ERROR");
        end
        $finish;
    endtask

    initial begin
        apply_reset();
        test_reset_defaults();
        test_temperature_bands();
        test_correction_modes();
        test_coefficient_extremes();
        test_random_traffic();
        finish_run();
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/bscu_pkg.sv
sv/bscu_pipe_ctrl.sv
sv/bscu_temp_path.sv
sv/bscu_press_path.sv
sv/baro_sensor_compensation_unit.sv
test/tb_baro_sensor_compensation_unit.sv
